[src/fpsa_pkg.sv]
// shared types and constants for the fixed pool slot allocator
// no dependencies
package fpsa_pkg;

	localparam int OPCODE_W      = 3;
	localparam int SLOT_W        = 12;
	localparam int DEFAULT_SLOTS = 4096;
	localparam int S_TDATA_W     = 16;
	localparam int M_TDATA_W     = 16;

	typedef enum logic [OPCODE_W-1:0] {
		OP_ALLOC  = 3'd0,
		OP_FREE   = 3'd1,
		OP_FIRST  = 3'd2,
		OP_NEXT   = 3'd3,
		OP_REINIT = 3'd4
	} opcode_t;

	typedef enum logic [6:0] {
		S_INIT = 7'b0000001,
		S_IDLE = 7'b0000010,
		S_NX   = 7'b0000100,
		S_A    = 7'b0001000,
		S_B    = 7'b0010000,
		S_C    = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

endpackage

[src/fixed_pool_slot_allocator_unit.sv]
// Fixed pool slot allocator: free and used doubly linked lists over SLOTS slots, kept in
// two link memories with one write port each. Allocate and free run three link write steps
// on the single write port of the prev-link memory, but allocate on an empty pool and free
// of an out-of-range slot skip them; next-used waits for its link read, and first-used and
// unknown opcodes go straight to the result. Reinitialise rewrites every slot's links one
// slot a cycle; after reset the same rechain sweep runs before the first item is taken. A
// finished result sits in an output register, so the next item is accepted while it waits;
// that item's own result then holds the sequencer until the register is taken. A link value
// of SLOTS is null.
// top level, depends on fpsa_pkg, fpsa_link_mem and fpsa_ctrl
module fixed_pool_slot_allocator_unit #(
	parameter int SLOTS = fpsa_pkg::DEFAULT_SLOTS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [fpsa_pkg::S_TDATA_W-1:0]  s_tdata,   // slot[11:0], zero fill
	input  logic [fpsa_pkg::OPCODE_W-1:0]   s_tuser,   // opcode[2:0]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [fpsa_pkg::M_TDATA_W-1:0]  m_tdata,   // result_slot[11:0], zero fill
	output logic [0:0]                      m_tuser    // found[0]
);
	import fpsa_pkg::*;

	localparam int AW = $clog2(SLOTS);
	localparam int LW = $clog2(SLOTS + 1);

	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [LW-1:0]     rd_prev;
	logic [LW-1:0]     rd_next;
	logic              prev_we;
	logic [AW-1:0]     prev_addr;
	logic [LW-1:0]     prev_wdata;
	logic              next_we;
	logic [AW-1:0]     next_addr;
	logic [LW-1:0]     next_wdata;
	logic [SLOT_W-1:0] out_slot;
	logic              out_found;

	fpsa_ctrl #(
		.SLOTS(SLOTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_opcode (s_tuser),
		.in_slot   (s_tdata[SLOT_W-1:0]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_slot  (out_slot),
		.out_found (out_found),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_prev   (rd_prev),
		.rd_next   (rd_next),
		.prev_we   (prev_we),
		.prev_addr (prev_addr),
		.prev_wdata(prev_wdata),
		.next_we   (next_we),
		.next_addr (next_addr),
		.next_wdata(next_wdata)
	);

	fpsa_link_mem #(
		.SLOTS(SLOTS)
	) u_link_mem (
		.clk       (clk),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_prev   (rd_prev),
		.rd_next   (rd_next),
		.prev_we   (prev_we),
		.prev_addr (prev_addr),
		.prev_wdata(prev_wdata),
		.next_we   (next_we),
		.next_addr (next_addr),
		.next_wdata(next_wdata)
	);

	assign m_tdata = {{(M_TDATA_W - SLOT_W){1'b0}}, out_slot};
	assign m_tuser = out_found;

endmodule

[src/fpsa_link_mem.sv]
// previous and next link memories, one write port each and a shared read address with registered read data
// depends on nothing outside this file
module fpsa_link_mem #(
	parameter int SLOTS = 4096
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [$clog2(SLOTS)-1:0]     rd_addr,
	output logic [$clog2(SLOTS+1)-1:0]   rd_prev,
	output logic [$clog2(SLOTS+1)-1:0]   rd_next,
	input  logic                         prev_we,
	input  logic [$clog2(SLOTS)-1:0]     prev_addr,
	input  logic [$clog2(SLOTS+1)-1:0]   prev_wdata,
	input  logic                         next_we,
	input  logic [$clog2(SLOTS)-1:0]     next_addr,
	input  logic [$clog2(SLOTS+1)-1:0]   next_wdata
);
	localparam int LW = $clog2(SLOTS + 1);

	logic [LW-1:0] prev_mem [SLOTS];
	logic [LW-1:0] next_mem [SLOTS];

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_addr] <= prev_wdata;
		end
		if (next_we) begin
			next_mem[next_addr] <= next_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_prev <= prev_mem[rd_addr];
			rd_next <= next_mem[rd_addr];
		end
	end

endmodule

[src/fpsa_ctrl.sv]
// sequencer for the slot allocator: list heads, link update steps, rechain sweep, result register
// depends on fpsa_pkg
module fpsa_ctrl #(
	parameter int SLOTS = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [fpsa_pkg::OPCODE_W-1:0] in_opcode,
	input  logic [fpsa_pkg::SLOT_W-1:0]   in_slot,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [fpsa_pkg::SLOT_W-1:0]   out_slot,
	output logic                         out_found,
	output logic                         rd_en,
	output logic [$clog2(SLOTS)-1:0]     rd_addr,
	input  logic [$clog2(SLOTS+1)-1:0]   rd_prev,
	input  logic [$clog2(SLOTS+1)-1:0]   rd_next,
	output logic                         prev_we,
	output logic [$clog2(SLOTS)-1:0]     prev_addr,
	output logic [$clog2(SLOTS+1)-1:0]   prev_wdata,
	output logic                         next_we,
	output logic [$clog2(SLOTS)-1:0]     next_addr,
	output logic [$clog2(SLOTS+1)-1:0]   next_wdata
);
	import fpsa_pkg::*;

	localparam int AW = $clog2(SLOTS);
	localparam int LW = $clog2(SLOTS + 1);
	localparam int WW = (LW > SLOT_W) ? LW : SLOT_W;
	localparam logic [LW-1:0] LINK_NULL = LW'(SLOTS);
	localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

	function automatic logic is_slot(input logic [LW-1:0] v);
		is_slot = (v < LINK_NULL);
	endfunction

	state_t        state_q;
	logic [AW-1:0] cnt_q;
	logic          init_reply_q;
	logic          is_alloc_q;
	logic [LW-1:0] cur_q;
	logic [LW-1:0] free_head_q;
	logic [LW-1:0] used_head_q;
	logic [LW-1:0] res_q;
	logic          found_q;
	logic          m_valid_q;
	logic [SLOT_W-1:0] m_slot_q;
	logic          m_found_q;

	logic [WW-1:0] slot_w;
	logic [WW-1:0] res_w;
	logic          slot_ok;
	logic [LW-1:0] cnt_l;
	logic          fh_slot;
	logic          uh_slot;
	logic          out_load;
	opcode_t       op_in;

	assign slot_w  = WW'(in_slot);
	assign res_w   = WW'(res_q);
	assign slot_ok = (slot_w < WW'(SLOTS));
	assign cnt_l   = LW'(cnt_q);
	assign fh_slot = is_slot(free_head_q);
	assign uh_slot = is_slot(used_head_q);
	assign op_in   = opcode_t'(in_opcode);

	// the finished result moves into the output register once that register is empty or being taken
	assign out_load = (state_q == S_OUT) && (!m_valid_q || out_ready);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = m_valid_q;
	assign out_slot  = m_slot_q;
	assign out_found = m_found_q;

	// the item's links are read in the accept cycle
	assign rd_en   = in_valid && in_ready;
	assign rd_addr = (op_in == OP_ALLOC) ? free_head_q[AW-1:0] : slot_w[AW-1:0];

	always_comb begin
		prev_we    = 1'b0;
		prev_addr  = cur_q[AW-1:0];
		prev_wdata = LINK_NULL;
		next_we    = 1'b0;
		next_addr  = cur_q[AW-1:0];
		next_wdata = LINK_NULL;
		case (state_q)
			S_INIT: begin
				prev_we    = 1'b1;
				prev_addr  = cnt_q;
				prev_wdata = (cnt_q == '0) ? LINK_NULL : cnt_l - LW'(1);
				next_we    = 1'b1;
				next_addr  = cnt_q;
				next_wdata = cnt_l + LW'(1);
			end
			S_A: begin
				if (is_alloc_q) begin
					// detach the popped slot's successor, point the slot at the used head
					prev_we    = is_slot(rd_next);
					prev_addr  = rd_next[AW-1:0];
					prev_wdata = LINK_NULL;
					next_we    = 1'b1;
					next_addr  = cur_q[AW-1:0];
					next_wdata = used_head_q;
				end else begin
					// unlink the slot from its neighbors
					next_we    = is_slot(rd_prev);
					next_addr  = rd_prev[AW-1:0];
					next_wdata = rd_next;
					prev_we    = is_slot(rd_next);
					prev_addr  = rd_next[AW-1:0];
					prev_wdata = rd_prev;
				end
			end
			S_B: begin
				prev_we    = 1'b1;
				prev_addr  = cur_q[AW-1:0];
				prev_wdata = LINK_NULL;
				if (!is_alloc_q) begin
					next_we    = 1'b1;
					next_addr  = cur_q[AW-1:0];
					next_wdata = fh_slot ? free_head_q : LINK_NULL;
				end
			end
			S_C: begin
				prev_wdata = cur_q;
				if (is_alloc_q) begin
					prev_we   = uh_slot;
					prev_addr = used_head_q[AW-1:0];
				end else begin
					prev_we   = fh_slot;
					prev_addr = free_head_q[AW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			cnt_q        <= '0;
			init_reply_q <= 1'b0;
			is_alloc_q   <= 1'b0;
			free_head_q  <= '0;
			used_head_q  <= LINK_NULL;
			m_valid_q    <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (out_ready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == LAST_SLOT) begin
						free_head_q <= '0;
						used_head_q <= LINK_NULL;
						state_q     <= init_reply_q ? S_OUT : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						is_alloc_q <= (op_in == OP_ALLOC);
						case (op_in)
							OP_ALLOC: begin
								state_q <= fh_slot ? S_A : S_OUT;
							end
							OP_FREE: begin
								state_q <= slot_ok ? S_A : S_OUT;
							end
							OP_FIRST: begin
								state_q <= S_OUT;
							end
							OP_NEXT: begin
								state_q <= slot_ok ? S_NX : S_OUT;
							end
							OP_REINIT: begin
								cnt_q        <= '0;
								init_reply_q <= 1'b1;
								state_q      <= S_INIT;
							end
							default: begin
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_NX: begin
					state_q <= S_OUT;
				end
				S_A: begin
					if (is_alloc_q) begin
						free_head_q <= rd_next;
					end else if (!is_slot(rd_prev)) begin
						used_head_q <= rd_next;
					end
					state_q <= S_B;
				end
				S_B: begin
					state_q <= S_C;
				end
				S_C: begin
					if (is_alloc_q) begin
						used_head_q <= cur_q;
					end else begin
						free_head_q <= cur_q;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working slot and result, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cur_q   <= (op_in == OP_ALLOC) ? free_head_q : slot_w[LW-1:0];
					res_q   <= (op_in == OP_FIRST && uh_slot) ? used_head_q : '0;
					found_q <= (op_in == OP_FIRST && uh_slot);
				end
			end
			S_INIT: begin
				res_q   <= '0;
				found_q <= 1'b0;
			end
			S_NX: begin
				res_q   <= is_slot(rd_next) ? rd_next : '0;
				found_q <= is_slot(rd_next);
			end
			S_C: begin
				res_q   <= cur_q;
				found_q <= 1'b1;
			end
			S_OUT: begin
				if (out_load) begin
					m_slot_q  <= res_w[SLOT_W-1:0];
					m_found_q <= found_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[bench/fpsa_checker.sv]
`timescale 1ns / 1ps
// result checker for the fixed pool slot allocator: keeps its own copy of the free and used
// link lists, predicts the result of every accepted item and compares it on the output side
// depends on fpsa_pkg
module fpsa_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [fpsa_pkg::S_TDATA_W-1:0]  s_tdata,   // slot[11:0], zero fill
	input  logic [fpsa_pkg::OPCODE_W-1:0]   s_tuser,   // opcode[2:0]
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [fpsa_pkg::M_TDATA_W-1:0]  m_tdata,   // result_slot[11:0], zero fill
	input  logic [0:0]                      m_tuser,   // found[0]
	output int                              errors,
	output int                              pending,
	output int                              checked,
	output int                              empty_allocs
);
	import fpsa_pkg::*;

	localparam int SLOTS = DEFAULT_SLOTS;
	// a link value of SLOTS marks the end of a list
	localparam logic [SLOT_W:0] NIL = (SLOT_W+1)'(SLOTS);

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              found;
	} answer_t;

	logic [SLOT_W:0] prev_of [SLOTS];
	logic [SLOT_W:0] next_of [SLOTS];
	logic [SLOT_W:0] free_top;
	logic [SLOT_W:0] used_top;
	answer_t         due_results[$];

	function automatic logic is_slot(input logic [SLOT_W:0] v);
		return !v[SLOT_W];
	endfunction

	function automatic void rechain();
		for (int i = 0; i < SLOTS; i++) begin
			prev_of[i] = (i == 0) ? NIL : (SLOT_W+1)'(i - 1);
			next_of[i] = (SLOT_W+1)'(i + 1);
		end
		free_top = '0;
		used_top = NIL;
	endfunction

	function automatic answer_t step_pool(input logic [OPCODE_W-1:0] op,
			input logic [SLOT_W-1:0] s);
		answer_t         a;
		logic [SLOT_W:0] n;
		logic [SLOT_W:0] after;
		logic [SLOT_W:0] p;
		logic [SLOT_W:0] nx;
		a = '0;
		case (op)
			OP_ALLOC: begin
				n = free_top;
				if (is_slot(n)) begin
					after = next_of[n];
					free_top = after;
					if (is_slot(after))
						prev_of[after] = NIL;
					prev_of[n] = NIL;
					next_of[n] = used_top;
					if (is_slot(used_top))
						prev_of[used_top] = n;
					used_top = n;
					a.slot = n[SLOT_W-1:0];
					a.found = 1'b1;
				end
			end
			OP_FREE: begin
				// no check that the slot is in use, the same relinking is done
				p = prev_of[s];
				nx = next_of[s];
				if (is_slot(p))
					next_of[p] = nx;
				else
					used_top = nx;
				if (is_slot(nx))
					prev_of[nx] = p;
				prev_of[s] = NIL;
				if (!is_slot(free_top)) begin
					next_of[s] = NIL;
				end else begin
					prev_of[free_top] = {1'b0, s};
					next_of[s] = free_top;
				end
				free_top = {1'b0, s};
				a.slot = s;
				a.found = 1'b1;
			end
			OP_FIRST: begin
				if (is_slot(used_top)) begin
					a.slot = used_top[SLOT_W-1:0];
					a.found = 1'b1;
				end
			end
			OP_NEXT: begin
				if (is_slot(next_of[s])) begin
					a.slot = next_of[s][SLOT_W-1:0];
					a.found = 1'b1;
				end
			end
			OP_REINIT: begin
				rechain();
			end
			default: begin
			end
		endcase
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		answer_t got;
		if (!arst_n) begin
			rechain();
			due_results.delete();
			errors = 0;
			checked = 0;
			empty_allocs = 0;
			pending <= 0;
		end else begin
			// output side first: a result never belongs to the item accepted at the same edge
			if (m_tvalid && m_tready) begin
				got.slot = m_tdata[SLOT_W-1:0];
				got.found = m_tuser[0];
				if (due_results.size() == 0) begin
					$display("%0t: result with nothing pending, slot %0d found %0b",
						$time, got.slot, got.found);
					errors++;
				end else begin
					want = due_results.pop_front();
					checked++;
					if (got.slot !== want.slot) begin
						$display("%0t: result_slot expected %0d, got %0d",
							$time, want.slot, got.slot);
						errors++;
					end
					if (got.found !== want.found) begin
						$display("%0t: found expected %0b, got %0b",
							$time, want.found, got.found);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				want = step_pool(s_tuser, s_tdata[SLOT_W-1:0]);
				if (s_tuser == OP_ALLOC && !want.found)
					empty_allocs++;
				due_results.insert(due_results.size(), want);
			end
			pending <= due_results.size();
		end
	end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// bench top for the fixed pool slot allocator: clock, reset, item stimulus with idle,
// stall and hold-off phases, watchdog and verdict
// depends on fpsa_pkg, fixed_pool_slot_allocator_unit and fpsa_checker
module tb;
	import fpsa_pkg::*;

	localparam int QUIET_LIMIT  = 20000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 180;
	localparam logic [OPCODE_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_SPARE_LAST  = 3'd7;

	typedef struct {
		logic [OPCODE_W-1:0] op;
		int                  tag;
	} sent_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [OPCODE_W-1:0]  s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [0:0]           m_tuser;

	int errors;
	int pending;
	int checked;
	int empty_allocs;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_len = 0;
	int idle_cycles = 0;
	int items_sent = 0;
	int reinits = 0;
	int era = 0;

	// slots known to be on the used list, so that most frees and walks are well formed
	logic [SLOT_W-1:0] used_pool[$];
	sent_t             sent_q[$];

	always #5 clk = ~clk;

	fixed_pool_slot_allocator_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	fpsa_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.errors       (errors),
		.pending      (pending),
		.checked      (checked),
		.empty_allocs (empty_allocs)
	);

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// allocations from before the last reinitialize are stale and not tracked
	always @(posedge clk) begin
		sent_t it;
		if (arst_n && m_tvalid && m_tready && sent_q.size() > 0) begin
			it = sent_q.pop_front();
			if (it.op == OP_ALLOC && m_tuser[0] && it.tag == era)
				used_pool.insert(used_pool.size(), m_tdata[SLOT_W-1:0]);
		end
	end

	// output side: random stalls, or one long hold-off when asked
	initial begin
		int n;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				n = hold_len;
				hold_len = 0;
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	function automatic void forget_slot(input logic [SLOT_W-1:0] s);
		foreach (used_pool[i]) begin
			if (used_pool[i] == s) begin
				used_pool.delete(i);
				return;
			end
		end
	endfunction

	function automatic logic [SLOT_W-1:0] any_used();
		return used_pool[$urandom_range(used_pool.size() - 1)];
	endfunction

	task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [SLOT_W-1:0] s);
		sent_t rec;
		if (op == OP_FREE)
			forget_slot(s);
		if (op == OP_REINIT) begin
			used_pool.delete();
			era++;
			reinits++;
		end
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {{(S_TDATA_W-SLOT_W){1'b0}}, s};
		do @(posedge clk); while (!s_tready);
		rec.op = op;
		rec.tag = era;
		sent_q.insert(sent_q.size(), rec);
		items_sent++;
	endtask

	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic run_random(input int count);
		int pick;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 40 || (pick < 64 && used_pool.size() == 0))
				send_item(OP_ALLOC, SLOT_W'($urandom));
			else if (pick < 64)
				send_item(OP_FREE, any_used());
			else if (pick < 67)
				send_item(OP_FREE, SLOT_W'($urandom));
			else if (pick < 77)
				send_item(OP_FIRST, SLOT_W'($urandom));
			else if (pick < 92 && used_pool.size() != 0)
				send_item(OP_NEXT, any_used());
			else if (pick < 95)
				send_item(OP_NEXT, SLOT_W'($urandom));
			else if (pick < 99)
				send_item(OP_SPARE_FIRST + OPCODE_W'($urandom_range(2)), SLOT_W'($urandom));
			else
				send_item(OP_REINIT, SLOT_W'($urandom));
		end
	endtask

	// freeing the free head folds the free list onto itself, so a few grants drain it
	task automatic exhaust_pool();
		send_item(OP_REINIT, SLOT_W'($urandom));
		send_item(OP_ALLOC, 12'd0);
		send_item(OP_FREE, 12'd1);        // free head, never handed out
		send_item(OP_FREE, 12'd0);
		repeat (4) send_item(OP_ALLOC, SLOT_W'($urandom));
		send_item(OP_ALLOC, SLOT_W'($urandom));  // free list is empty now
		send_item(OP_FREE, 12'd9);        // free onto an empty free list
		repeat (2) send_item(OP_ALLOC, SLOT_W'($urandom));
		send_item(OP_FIRST, SLOT_W'($urandom));
		send_item(OP_REINIT, SLOT_W'($urandom));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		send_item(OP_FIRST, 12'd0);       // used list still empty
		send_item(OP_NEXT, 12'd0);        // link inside the fresh free chain
		send_item(OP_ALLOC, 12'hfff);
		send_item(OP_ALLOC, 12'd0);
		send_item(OP_ALLOC, 12'h555);
		send_item(OP_FIRST, 12'haaa);
		send_item(OP_NEXT, 12'd2);
		send_item(OP_NEXT, 12'd1);
		send_item(OP_NEXT, 12'd0);        // end of the used list
		send_item(OP_FREE, 12'd1);        // middle of the used list
		send_item(OP_FREE, 12'd2);        // head of the used list
		send_item(OP_FREE, 12'd0);        // last one, used list empty again
		send_item(OP_FREE, 12'hfff);      // slot that was never handed out
		send_item(OP_ALLOC, 12'd0);
		send_item(OP_NEXT, 12'hfff);
		send_item(OP_SPARE_FIRST, 12'hfff);
		send_item(OP_SPARE_FIRST + 3'd1, 12'h000);
		send_item(OP_SPARE_LAST, 12'h800);
		send_item(OP_REINIT, 12'hfff);
		send_item(OP_FIRST, 12'd0);
		send_item(OP_ALLOC, 12'd0);
		wait_quiet();

		run_random(PHASE_ITEMS / 2);
		// long output hold-off while items keep coming, so the input backs up
		hold_len = HOLD_CYCLES;
		run_random(40);
		run_random(PHASE_ITEMS / 2);
		wait_quiet();

		tx_idle_pct = 53;
		run_random(PHASE_ITEMS);
		wait_quiet();

		tx_idle_pct = 0;
		rx_stall_pct = 53;
		run_random(PHASE_ITEMS);
		wait_quiet();

		tx_idle_pct = 22;
		rx_stall_pct = 22;
		run_random(PHASE_ITEMS);
		wait_quiet();

		tx_idle_pct = 0;
		rx_stall_pct = 0;
		exhaust_pool();
		wait_quiet();
		repeat (20) @(posedge clk);

		$display("covered %0d items, %0d pool reinitializations, %0d allocations on an empty pool",
			items_sent, reinits, empty_allocs);
		$display("%0d results compared across idle, stall and long hold-off phases", checked);
		if (errors == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[files.f]
src/fpsa_pkg.sv
src/fpsa_link_mem.sv
src/fpsa_ctrl.sv
src/fixed_pool_slot_allocator_unit.sv
bench/fpsa_checker.sv
bench/tb.sv
